// ----- src/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the battery level smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

    // field widths
    localparam int LEVEL_IN_W = 9;
    localparam int PCT_W      = 7;
    localparam int ACC_W      = 11;
    localparam int TIME_W     = 32;
    localparam int CHG_W      = 2;
    localparam int STREAK_W   = 8;
    localparam int SHIFT_W    = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    // apb register map
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam logic [2:0] REG_POLL_INTERVAL = 3'd0;
    localparam logic [2:0] REG_SMOOTH_SHIFT  = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS    = 3'd2;
    localparam logic [2:0] REG_CONFIRM_POLLS = 3'd3;
    localparam logic [2:0] REG_LOW_PERCENT   = 3'd4;

    // charge report codes
    localparam logic [CHG_W-1:0] CHG_UNKNOWN     = 2'd0;
    localparam logic [CHG_W-1:0] CHG_CHARGING    = 2'd1;
    localparam logic [CHG_W-1:0] CHG_DISCHARGING = 2'd2;

    // input selector codes
    localparam logic ACT_POLL_CHECK = 1'b0;
    localparam logic ACT_READING    = 1'b1;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // filter keeps sixteen times the level
    localparam int ACC_FRAC = 4;
    localparam logic [ACC_W-1:0] ACC_HALF = 11'd8;

    // register reset values
    localparam logic [TIME_W-1:0]   RST_POLL_INTERVAL = 32'd30000;
    localparam logic [SHIFT_W-1:0]  RST_SMOOTH_SHIFT  = 3'd2;
    localparam logic [PCT_W-1:0]    RST_HYSTERESIS    = 7'd2;
    localparam logic [STREAK_W-1:0] RST_CONFIRM_POLLS = 8'd3;
    localparam logic [PCT_W-1:0]    RST_LOW_PERCENT   = 7'd15;

    typedef struct packed {
        logic [TIME_W-1:0]   poll_interval_ms;
        logic [SHIFT_W-1:0]  smoothing_shift;
        logic [PCT_W-1:0]    hysteresis_percent;
        logic [STREAK_W-1:0] discharge_confirm_polls;
        logic [PCT_W-1:0]    low_percent;
    } t_cfg;

    typedef struct packed {
        logic                         action;
        logic signed [LEVEL_IN_W-1:0] reported_level;
        logic [CHG_W-1:0]             charge_report;
        logic [TIME_W-1:0]            now_ms;
    } t_item;

    typedef struct packed {
        logic             poll_due;
        logic             label_changed;
        logic             level_known;
        logic [PCT_W-1:0] shown_percent;
        logic             charging;
        logic             battery_low;
    } t_result;

endpackage

`default_nettype wire

// ----- src/bls_cfg.sv -----
// ----------------------------------------------------------------------------
// bls_cfg
// APB register file holding the smoother settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_cfg
    import bls_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_ms        <= RST_POLL_INTERVAL;
            r_cfg.smoothing_shift         <= RST_SMOOTH_SHIFT;
            r_cfg.hysteresis_percent      <= RST_HYSTERESIS;
            r_cfg.discharge_confirm_polls <= RST_CONFIRM_POLLS;
            r_cfg.low_percent             <= RST_LOW_PERCENT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POLL_INTERVAL: r_cfg.poll_interval_ms        <= pwdata;
                REG_SMOOTH_SHIFT:  r_cfg.smoothing_shift         <= pwdata[SHIFT_W-1:0];
                REG_HYSTERESIS:    r_cfg.hysteresis_percent      <= pwdata[PCT_W-1:0];
                REG_CONFIRM_POLLS: r_cfg.discharge_confirm_polls <= pwdata[STREAK_W-1:0];
                REG_LOW_PERCENT:   r_cfg.low_percent             <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POLL_INTERVAL: prdata = r_cfg.poll_interval_ms;
            REG_SMOOTH_SHIFT:  prdata = {{(PDATA_W-SHIFT_W){1'b0}}, r_cfg.smoothing_shift};
            REG_HYSTERESIS:    prdata = {{(PDATA_W-PCT_W){1'b0}}, r_cfg.hysteresis_percent};
            REG_CONFIRM_POLLS: prdata = {{(PDATA_W-STREAK_W){1'b0}},
                                         r_cfg.discharge_confirm_polls};
            REG_LOW_PERCENT:   prdata = {{(PDATA_W-PCT_W){1'b0}}, r_cfg.low_percent};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- src/bls_core.sv -----
// ----------------------------------------------------------------------------
// bls_core
// Smoother state and the combinational next-state update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_core
    import bls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    logic                r_polled;
    logic [TIME_W-1:0]   r_last_poll;
    logic                r_acc_known;
    logic [ACC_W-1:0]    r_acc;
    logic                r_lvl_known;
    logic [PCT_W-1:0]    r_lvl;
    logic [CHG_W-1:0]    r_chg;
    logic [STREAK_W-1:0] r_streak;
    logic                r_label_valid;

    logic                n_acc_known;
    logic [ACC_W-1:0]    n_acc;
    logic                n_lvl_known;
    logic [PCT_W-1:0]    n_lvl;
    logic [CHG_W-1:0]    n_chg;
    logic [STREAK_W-1:0] n_streak;

    logic                w_is_read;
    logic                w_unknown;
    logic [PCT_W-1:0]    w_reading;
    logic [ACC_W-1:0]    w_seed;
    logic signed [12:0]  w_diff;
    logic signed [12:0]  w_bias;
    logic signed [12:0]  w_step;
    logic signed [12:0]  w_stepped;
    logic [ACC_W-1:0]    w_acc_upd;
    logic [ACC_W-1:0]    w_rounded;
    logic [PCT_W-1:0]    w_smoothed;
    logic signed [8:0]   w_delta;
    logic [8:0]          w_abs;
    logic                w_hold;
    logic [STREAK_W-1:0] w_streak_inc;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_poll_due;
    logic                w_changed;
    logic                w_chg_now;
    logic                w_known_out;
    logic [PCT_W-1:0]    w_lvl_out;
    logic [CHG_W-1:0]    w_chg_out;

    assign w_is_read = (i_item.action == ACT_READING);
    assign w_unknown = i_item.reported_level[LEVEL_IN_W-1];

    // clamp to full scale
    assign w_reading = (i_item.reported_level[7:0] > {1'b0, PCT_MAX}) ? PCT_MAX
                                                                       : i_item.reported_level[6:0];
    assign w_seed    = {w_reading, {ACC_FRAC{1'b0}}};

    // step toward the reading, divide truncating toward zero
    assign w_diff    = $signed({2'b00, w_seed}) - $signed({2'b00, r_acc});
    assign w_bias    = w_diff[12] ? $signed(~(13'h1FFF << i_cfg.smoothing_shift)) : 13'sd0;
    assign w_step    = (w_diff + w_bias) >>> i_cfg.smoothing_shift;
    assign w_stepped = $signed({2'b00, r_acc}) + w_step;
    assign w_acc_upd = r_acc_known ? w_stepped[ACC_W-1:0] : w_seed;

    assign w_rounded  = w_acc_upd + ACC_HALF;
    assign w_smoothed = w_rounded[ACC_W-1:ACC_FRAC];

    assign w_delta = $signed({2'b00, w_smoothed}) - $signed({2'b00, r_lvl});
    assign w_abs   = w_delta[8] ? 9'(-w_delta) : 9'(w_delta);
    assign w_hold  = r_lvl_known && (w_abs < {2'b00, i_cfg.hysteresis_percent});

    always_comb begin
        if (w_unknown) begin
            n_acc_known = 1'b0;
            n_acc       = '0;
            n_lvl_known = 1'b0;
            n_lvl       = '0;
        end else begin
            n_acc_known = 1'b1;
            n_acc       = w_acc_upd;
            n_lvl_known = 1'b1;
            n_lvl       = w_hold ? r_lvl : w_smoothed;
        end
    end

    assign w_streak_inc = r_streak + 8'd1;

    // leaving the charging state needs a streak of discharging reports
    always_comb begin
        n_chg    = r_chg;
        n_streak = r_streak;
        case (i_item.charge_report)
            CHG_CHARGING: begin
                n_chg    = CHG_CHARGING;
                n_streak = '0;
            end
            CHG_DISCHARGING: begin
                if (r_chg != CHG_CHARGING ||
                    w_streak_inc >= i_cfg.discharge_confirm_polls) begin
                    n_chg    = CHG_DISCHARGING;
                    n_streak = '0;
                end else begin
                    n_streak = w_streak_inc;
                end
            end
            default: ;
        endcase
    end

    assign w_elapsed  = i_item.now_ms - r_last_poll;
    assign w_poll_due = !r_polled || (w_elapsed >= i_cfg.poll_interval_ms);

    always_comb begin
        if (!r_label_valid || (r_lvl_known != n_lvl_known)) begin
            w_changed = 1'b1;
        end else if (n_lvl_known) begin
            w_changed = (r_lvl != n_lvl) ||
                        ((r_chg == CHG_CHARGING) != (n_chg == CHG_CHARGING));
        end else begin
            w_changed = 1'b0;
        end
    end

    assign w_known_out = w_is_read ? n_lvl_known : r_lvl_known;
    assign w_lvl_out   = w_is_read ? n_lvl : r_lvl;
    assign w_chg_out   = w_is_read ? n_chg : r_chg;
    assign w_chg_now   = (w_chg_out == CHG_CHARGING);

    always_comb begin
        o_result.poll_due      = w_is_read ? 1'b0 : w_poll_due;
        o_result.label_changed = w_is_read ? w_changed : 1'b0;
        o_result.level_known   = w_known_out;
        o_result.shown_percent = w_known_out ? w_lvl_out : '0;
        o_result.charging      = w_chg_now;
        o_result.battery_low   = w_known_out && !w_chg_now &&
                                 (w_lvl_out <= i_cfg.low_percent);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polled      <= 1'b0;
            r_last_poll   <= '0;
            r_acc_known   <= 1'b0;
            r_acc         <= '0;
            r_lvl_known   <= 1'b0;
            r_lvl         <= '0;
            r_chg         <= CHG_UNKNOWN;
            r_streak      <= '0;
            r_label_valid <= 1'b0;
        end else if (i_en && w_is_read) begin
            r_polled      <= 1'b1;
            r_last_poll   <= i_item.now_ms;
            r_acc_known   <= n_acc_known;
            r_acc         <= n_acc;
            r_lvl_known   <= n_lvl_known;
            r_lvl         <= n_lvl;
            r_chg         <= n_chg;
            r_streak      <= n_streak;
            r_label_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/battery_level_smoother_top.sv -----
// ----------------------------------------------------------------------------
// battery_level_smoother_top
// Battery level smoother with poll timing, filtering and charge debounce.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------
//  s stream | in        | i_s_tvalid / o_s_tready     | i_s_tdata, i_s_tuser
//  m stream | out       | o_m_tvalid / i_m_tready     | o_m_tdata
//  apb      | in        | psel, penable, pwrite/pready| paddr, pwdata, prdata
//
//  one result per item; an item waits in the input register and is
//  evaluated and updates the state while it moves into the result register
//  an accepted item passes the input register, then the result register, to
//  o_m_tvalid; throughput one item per cycle while the sink takes results
//  a stall on the output stops the input register; up to two items are held
//  reset is synchronous, active low; config and core state come up at defaults
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_smoother_top
    import bls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // reported_level, charge_report, now_ms
    input  wire logic                 i_s_tuser,  // action
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata,  // poll_due, label_changed, level_known,
                                                  // shown_percent, charging, battery_low
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_take;

    bls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action         <= i_s_tuser;
            r_in.reported_level <= i_s_tdata[8:0];
            r_in.charge_report  <= i_s_tdata[10:9];
            r_in.now_ms         <= i_s_tdata[42:11];
        end
    end

    bls_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.battery_low, r_out.charging, r_out.shown_percent,
                         r_out.level_known, r_out.label_changed, r_out.poll_due};

endmodule

`default_nettype wire

// ----- src/bls_checker.sv -----
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks for the battery level smoother, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_checker
    import bls_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);

    // held result must not move while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a poll answer never carries a label change
    a_poll_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("poll_due and label_changed both set");

    // unknown level shows zero and is never low
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[2] |-> (o_m_tdata[9:3] == '0) && !o_m_tdata[11])
        else $error("unknown level reported with a value");

    // shown level stays within full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[9:3] <= PCT_MAX))
        else $error("shown level above full scale");

    // low flag is suppressed while charging
    a_low_not_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10] |-> !o_m_tdata[11])
        else $error("battery_low while charging");

endmodule

bind battery_level_smoother_top bls_checker u_bls_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ----- tb/sv/battery_level_smoother_top_tb.sv -----
// ----------------------------------------------------------------------------
// battery_level_smoother_top_tb
// Self-checking bench for the battery level smoother. Poll checks and
// readings go in over the input stream with bursty timing while the output
// side stalls on its own pattern. Each result is compared field by field
// against a cycle-free prediction of the filter, hysteresis and charge
// debounce. Registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------

module battery_level_smoother_top_tb;
    import bls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASE_ITEMS = 305;
    // charge code with no meaning, the shown state must be kept
    localparam logic [CHG_W-1:0] CHG_RESERVED = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;  // reported_level, charge_report, now_ms
    logic                 i_s_tuser = 1'b0;  // action
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;  // poll_due, label_changed, level_known,
                                      // shown_percent, charging, battery_low
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    battery_level_smoother_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predicted copy of the block's registers and state
    t_cfg              cfg = '{RST_POLL_INTERVAL, RST_SMOOTH_SHIFT, RST_HYSTERESIS,
                               RST_CONFIRM_POLLS, RST_LOW_PERCENT};
    bit                seen_reading = 1'b0;
    logic [TIME_W-1:0] last_reading_ms = '0;
    int                acc_x16 = -1;
    int                level_on_display = -1;
    logic [CHG_W-1:0]  charge_on_display = CHG_UNKNOWN;
    logic [7:0]        discharge_run = '0;
    bit                label_shown = 1'b0;

    t_result pending_displays[$];

    int mismatches = 0;
    int results_checked = 0;
    int polls_sent = 0;
    int readings_sent = 0;
    int settings_used = 1;
    int burst_left = 0;
    int idle_cycles = 0;

    // stimulus context for the random phases
    logic [TIME_W-1:0] clock_ms = '0;
    int                drift_level = 50;
    logic [CHG_W-1:0]  charge_mode = CHG_DISCHARGING;

    function automatic t_result compute_display(input t_item it);
        t_result           r;
        int                lvl, rdg, diff, smoothed, delta, h, prev_level;
        bit                prev_known, prev_chg, take, known, chg;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        prev_known = level_on_display >= 0;
        prev_level = level_on_display;
        prev_chg = charge_on_display == CHG_CHARGING;
        if (it.action == ACT_POLL_CHECK) begin
            elapsed = it.now_ms - last_reading_ms;
            r.poll_due = !seen_reading || elapsed >= cfg.poll_interval_ms;
        end else begin
            seen_reading = 1'b1;
            last_reading_ms = it.now_ms;
            lvl = int'($signed(it.reported_level));
            if (lvl < 0) begin
                acc_x16 = -1;
                level_on_display = -1;
            end else begin
                rdg = (lvl > int'(PCT_MAX)) ? int'(PCT_MAX) : lvl;
                if (acc_x16 < 0) begin
                    acc_x16 = rdg * 16;
                end else begin
                    // signed division truncates toward zero
                    diff = rdg * 16 - acc_x16;
                    acc_x16 += diff / (1 << cfg.smoothing_shift);
                end
                smoothed = (acc_x16 + 8) / 16;
                delta = smoothed - level_on_display;
                h = int'(cfg.hysteresis_percent);
                if (!(level_on_display >= 0 && delta < h && delta > -h))
                    level_on_display = smoothed;
            end
            if (it.charge_report == CHG_CHARGING) begin
                charge_on_display = CHG_CHARGING;
                discharge_run = '0;
            end else if (it.charge_report == CHG_DISCHARGING) begin
                take = 1'b1;
                if (charge_on_display == CHG_CHARGING) begin
                    discharge_run = discharge_run + 8'd1;
                    take = discharge_run >= cfg.discharge_confirm_polls;
                end
                if (take) begin
                    charge_on_display = CHG_DISCHARGING;
                    discharge_run = '0;
                end
            end
            known = level_on_display >= 0;
            chg = charge_on_display == CHG_CHARGING;
            if (!label_shown || prev_known != known)
                r.label_changed = 1'b1;
            else if (known)
                r.label_changed = prev_level != level_on_display || prev_chg != chg;
            label_shown = 1'b1;
        end
        known = level_on_display >= 0;
        chg = charge_on_display == CHG_CHARGING;
        r.level_known = known;
        r.shown_percent = known ? level_on_display[PCT_W-1:0] : '0;
        r.charging = chg;
        r.battery_low = known && level_on_display <= int'(cfg.low_percent) && !chg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on result %0d, %0s: got %0d, want %0d",
                 $realtime, results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic compare_display(input t_result got, input t_result want);
        if (got.poll_due != want.poll_due)
            report_mismatch("poll_due", int'(got.poll_due), int'(want.poll_due));
        if (got.label_changed != want.label_changed)
            report_mismatch("label_changed", int'(got.label_changed),
                            int'(want.label_changed));
        if (got.level_known != want.level_known)
            report_mismatch("level_known", int'(got.level_known), int'(want.level_known));
        if (got.shown_percent != want.shown_percent)
            report_mismatch("shown_percent", int'(got.shown_percent),
                            int'(want.shown_percent));
        if (got.charging != want.charging)
            report_mismatch("charging", int'(got.charging), int'(want.charging));
        if (got.battery_low != want.battery_low)
            report_mismatch("battery_low", int'(got.battery_low), int'(want.battery_low));
    endtask

    // result side: outputs are read at the edge, before the block updates them
    t_result got_display;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_display.poll_due      = o_m_tdata[0];
            got_display.label_changed = o_m_tdata[1];
            got_display.level_known   = o_m_tdata[2];
            got_display.shown_percent = o_m_tdata[9:3];
            got_display.charging      = o_m_tdata[10];
            got_display.battery_low   = o_m_tdata[11];
            if (pending_displays.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
                compare_display(got_display, pending_displays.pop_front());
            results_checked++;
        end
    end

    // receiver: steady, light, periodic and heavy stall stretches
    int sink_mode = 0;
    int sink_left = 0;
    logic [3:0] sink_phase = '0;
    always @(posedge i_clk) begin
        sink_phase <= sink_phase + 4'd1;
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(20, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= $urandom_range(0, 3) != 0;
            end
            2: begin
                i_m_tready <= sink_phase[2];
            end
            default: begin
                i_m_tready <= $urandom_range(0, 3) == 0;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     STALL_LIMIT, pending_displays.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_item it);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.action;
        i_s_tdata  <= {5'd0, it.now_ms, it.charge_report, it.reported_level};
        do @(posedge i_clk); while (!o_s_tready);
        pending_displays.push_back(compute_display(it));
        if (it.action == ACT_POLL_CHECK)
            polls_sent++;
        else
            readings_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic poll_check(input logic [TIME_W-1:0] now);
        t_item it;
        it = '0;
        it.action = ACT_POLL_CHECK;
        it.reported_level = LEVEL_IN_W'($urandom_range(0, 511));
        it.charge_report = CHG_W'($urandom_range(0, 3));
        it.now_ms = now;
        send_item(it);
    endtask

    task automatic reading(input int lvl, input logic [CHG_W-1:0] chg,
                           input logic [TIME_W-1:0] now);
        t_item it;
        it.action = ACT_READING;
        it.reported_level = lvl[LEVEL_IN_W-1:0];
        it.charge_report = chg;
        it.now_ms = now;
        send_item(it);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POLL_INTERVAL: cfg.poll_interval_ms = val;
            REG_SMOOTH_SHIFT:  cfg.smoothing_shift = val[SHIFT_W-1:0];
            REG_HYSTERESIS:    cfg.hysteresis_percent = val[PCT_W-1:0];
            REG_CONFIRM_POLLS: cfg.discharge_confirm_polls = val[STREAK_W-1:0];
            REG_LOW_PERCENT:   cfg.low_percent = val[PCT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] interval, input int shift, input int hyst,
                             input int confirm, input int low);
        drain_results();
        write_reg(REG_POLL_INTERVAL, interval);
        write_reg(REG_SMOOTH_SHIFT, shift);
        write_reg(REG_HYSTERESIS, hyst);
        write_reg(REG_CONFIRM_POLLS, confirm);
        write_reg(REG_LOW_PERCENT, low);
        settings_used++;
    endtask

    // reset values: first poll is due, first reading reports a change
    task automatic test_first_contact();
        poll_check(32'd0);
        reading(50, CHG_CHARGING, 32'd1000);
        poll_check(32'd30999);
        poll_check(32'd31000);
    endtask

    // clamping, unknown levels, reserved charge code, debounce of discharging
    task automatic test_level_extremes();
        reading(255, CHG_RESERVED, 32'hFFFF_FFFF);
        reading(101, CHG_UNKNOWN, 32'd200);
        reading(100, CHG_DISCHARGING, 32'd300);
        reading(0, CHG_DISCHARGING, 32'd400);
        reading(0, CHG_DISCHARGING, 32'd450);
        reading(-1, CHG_DISCHARGING, 32'd480);
        reading(-256, CHG_CHARGING, 32'd500);
        // elapsed time wraps past zero
        poll_check(32'd0);
    endtask

    // zero hysteresis, zero confirm count, zero interval, then the other ends
    task automatic test_register_extremes();
        configure(32'd0, 0, 0, 0, 100);
        reading(40, CHG_CHARGING, 32'd10);
        reading(41, CHG_DISCHARGING, 32'd20);
        poll_check(32'd20);
        reading(15, CHG_DISCHARGING, 32'd30);
        configure(32'hFFFF_FFFF, 7, 100, 255, 0);
        reading(0, CHG_CHARGING, 32'd1000);
        reading(100, CHG_DISCHARGING, 32'd1000);
        poll_check(32'd998);
        poll_check(32'd999);
        reading(-5, CHG_UNKNOWN, 32'd1200);
        reading(7, CHG_DISCHARGING, 32'd1300);
    endtask

    // mostly plausible drifting readings and sticky charge reports, some noise
    task automatic test_random_phase(input int count);
        int pick, lvl;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_ms = clock_ms + $urandom_range(0, 45000);
            else if (pick < 90)
                clock_ms = clock_ms + $urandom_range(0, 3);
            else if (pick < 97)
                clock_ms = clock_ms + $urandom();
            else
                clock_ms = $urandom();
            if ($urandom_range(0, 3) == 0)
                charge_mode = CHG_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 3) begin
                poll_check(clock_ms);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    drift_level += $urandom_range(0, 10) - 5;
                    drift_level = drift_level < 0 ? 0 : (drift_level > 100 ? 100 : drift_level);
                    lvl = drift_level + $urandom_range(0, 4) - 2;
                end else if (pick < 80) begin
                    drift_level = $urandom_range(0, 100);
                    lvl = drift_level;
                end else if (pick < 90) begin
                    lvl = $urandom_range(0, 511) - 256;
                end else if (pick < 95) begin
                    lvl = -$urandom_range(1, 256);
                end else begin
                    lvl = $urandom_range(101, 255);
                end
                reading(lvl, charge_mode, clock_ms);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_contact();
        test_level_extremes();
        test_register_extremes();

        configure(RST_POLL_INTERVAL, 2, 2, 3, 15);
        test_random_phase(RANDOM_PHASE_ITEMS);
        configure($urandom_range(0, 60000), $urandom_range(0, 7), $urandom_range(0, 10),
                  $urandom_range(1, 8), $urandom_range(0, 100));
        test_random_phase(RANDOM_PHASE_ITEMS);
        configure(32'd0, 7, 0, 1, 100);
        test_random_phase(RANDOM_PHASE_ITEMS);
        configure(32'hFFFF_FFFF, 0, 100, 255, 0);
        test_random_phase(RANDOM_PHASE_ITEMS);
        configure($urandom_range(0, 60000), $urandom_range(0, 7), $urandom_range(0, 100),
                  $urandom_range(0, 255), $urandom_range(0, 100));
        test_random_phase(RANDOM_PHASE_ITEMS);
        configure($urandom(), $urandom_range(0, 7), $urandom_range(0, 5),
                  $urandom_range(0, 4), $urandom_range(0, 100));
        test_random_phase(RANDOM_PHASE_ITEMS);

        drain_results();
        $display("sent %0d poll checks and %0d readings across %0d register settings",
                 polls_sent, readings_sent, settings_used);
        $display("compared %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_displays.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d results never arrived", pending_displays.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
